// ===== src/sssp_pkg.sv =====
// shared types, constants and controller codes for the shortest path block
package sssp_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int WeightBits = 16;
  localparam int VertexBits = $clog2(MaxVertices);
  localparam int CountBits = VertexBits + 1;
  localparam int EdgeAddrBits = $clog2(MaxEdges);
  localparam int EdgeCountBits = EdgeAddrBits + 1;
  localparam int DistBits = 24;
  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};
  localparam int EdgeWordBits = 2 * VertexBits + WeightBits;

  // input item modes
  localparam logic ModeAdd = 1'b0;
  localparam logic ModeRun = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_END,
    ST_SETTLE,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_WB,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic       load_run;
    logic       add_edge;
    logic       mark_src;
    logic       scan_start;
    logic       scan_step;
    logic       scan_last;
    logic       settle;
    logic       edge_chk;
    logic       edge_wb;
    logic       out_rd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       add_ok;
    logic       src_ok;
    logic       scan_end;
    logic       found;
    logic       no_edges;
    logic       edge_end;
    logic       out_last;
  } status_t;
endpackage

// ===== src/sssp_ram.sv =====
// generic single port ram with registered read
module sssp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/sssp_datapath.sv =====
// datapath: edge store, per-vertex state, minimum scan and relaxation
module sssp_datapath import sssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CountBits-1:0]   cfg_data,
  input  logic [VertexBits-1:0]  from_vertex,
  input  logic [VertexBits-1:0]  to_vertex,
  input  logic [15:0]            edge_weight,
  input  logic [VertexBits-1:0]  source_vertex,
  output logic [VertexBits-1:0]  vertex,
  output logic [DistBits-1:0]    distance,
  output logic                   unreachable,
  output logic                   last
);
  logic [CountBits-1:0]     vertex_count;
  logic [CountBits-1:0]     n_act;
  logic [EdgeCountBits-1:0] edges_stored;
  logic [CountBits-1:0]     vcnt;
  logic [EdgeCountBits-1:0] ecnt;
  logic [VertexBits-1:0]    src;
  logic [VertexBits-1:0]    best_v;
  logic [DistBits-1:0]      best_d;
  logic                     found;
  logic [DistBits-1:0]      u_dist;
  logic [VertexBits-1:0]    u_idx;
  logic [MaxVertices-1:0]   reached;
  logic [MaxVertices-1:0]   settled;
  logic [DistBits-1:0]      cand;
  logic                     hit;
  logic                     scan_take;

  logic                     e_we;
  logic [EdgeAddrBits-1:0]  e_addr;
  logic [EdgeWordBits-1:0]  e_wdata;
  logic [EdgeWordBits-1:0]  e_rdata;
  logic                     d_we;
  logic [VertexBits-1:0]    d_addr;
  logic [DistBits-1:0]      d_wdata;
  logic [DistBits-1:0]      d_rdata;

  logic [VertexBits-1:0]    e_tail;
  logic [VertexBits-1:0]    e_head;
  logic [WeightBits-1:0]    e_cost;
  logic [DistBits:0]        sum;
  logic [VertexBits-1:0]    vidx;
  logic [VertexBits-1:0]    vidx_d;
  logic                     scan_valid;

  assign n_act = (vertex_count == '0) ? CountBits'(1) :
                 (vertex_count > CountBits'(MaxVertices)) ? CountBits'(MaxVertices) :
                 vertex_count;
  assign vidx = vcnt[VertexBits-1:0];
  assign {e_tail, e_head, e_cost} = e_rdata;
  assign sum = {1'b0, u_dist} + (DistBits+1)'(e_cost);
  assign cand = sum[DistBits] ? DistMax : sum[DistBits-1:0];

  // valid in the write back cycle: edge word and head distance are both read out
  assign hit = (e_tail == u_idx) && ({1'b0, e_head} < n_act) &&
               (!reached[e_head] || cand < d_rdata);
  assign scan_take = scan_valid && reached[vidx_d] && !settled[vidx_d] &&
                     (!found || d_rdata < best_d);

  always_comb begin
    status.add_ok = (edges_stored < EdgeCountBits'(MaxEdges)) &&
                    ({1'b0, from_vertex} < n_act) && ({1'b0, to_vertex} < n_act);
    status.src_ok = ({1'b0, src} < n_act);
    status.scan_end = (vcnt + CountBits'(1) >= n_act);
    status.found = found;
    status.no_edges = (edges_stored == '0);
    status.edge_end = (ecnt + EdgeCountBits'(1) >= edges_stored);
    status.out_last = last;
  end

  sssp_ram #(.Width(EdgeWordBits), .Depth(MaxEdges)) u_edges (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );
  sssp_ram #(.Width(DistBits), .Depth(MaxVertices)) u_dist_ram (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
  );

  always_comb begin
    e_we = cmd.add_edge;
    e_addr = cmd.add_edge ? edges_stored[EdgeAddrBits-1:0] : ecnt[EdgeAddrBits-1:0];
    e_wdata = {from_vertex, to_vertex, edge_weight[WeightBits-1:0]};
    d_we = 1'b0;
    d_addr = vidx;
    d_wdata = '0;
    if (cmd.load_run) begin
      d_we = 1'b1;
      d_addr = source_vertex;
    end else if (cmd.edge_chk) begin
      d_addr = e_head;
    end else if (cmd.edge_wb) begin
      d_we = hit;
      d_addr = e_head;
      d_wdata = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CountBits'(MaxVertices);
      edges_stored <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (cmd.add_edge) begin
        edges_stored <= edges_stored + EdgeCountBits'(1);
      end
    end
  end

  // the scan reads one distance a cycle; read data arrives in the cycle after the read
  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      src <= source_vertex;
      reached <= '0;
      settled <= '0;
    end
    if (cmd.mark_src) begin
      reached[src] <= 1'b1;
    end
    if (cmd.scan_start) begin
      vcnt <= '0;
      found <= 1'b0;
      scan_valid <= 1'b0;
    end
    if (cmd.scan_step) begin
      vcnt <= vcnt + CountBits'(1);
      vidx_d <= vidx;
      scan_valid <= 1'b1;
    end
    if ((cmd.scan_step || cmd.scan_last) && scan_take) begin
      found <= 1'b1;
      best_v <= vidx_d;
      best_d <= d_rdata;
    end
    // settle: take the winner and rewind the edge walk
    if (cmd.settle) begin
      settled[best_v] <= 1'b1;
      u_idx <= best_v;
      u_dist <= best_d;
      ecnt <= '0;
    end
    if (cmd.edge_wb) begin
      ecnt <= ecnt + EdgeCountBits'(1);
      if (hit) begin
        reached[e_head] <= 1'b1;
      end
    end
    if (cmd.out_rd) begin
      vcnt <= vcnt + CountBits'(1);
      vidx_d <= vidx;
    end
    if (cmd.out_load) begin
      vertex <= vidx_d;
      unreachable <= !reached[vidx_d];
      distance <= reached[vidx_d] ? d_rdata : DistMax;
      last <= (vcnt == n_act);
    end
  end
endmodule

// ===== src/sssp_ctrl.sv =====
// controller state machine for edge loads, runs and result streaming
module sssp_ctrl import sssp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    mode,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode == ModeAdd) begin
            cmd.add_edge = status.add_ok;
          end else begin
            cmd.load_run = 1'b1;
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd.mark_src = status.src_ok;
        cmd.scan_start = 1'b1;
        state_next = status.src_ok ? ST_SCAN : ST_OUT_RD;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_end) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.scan_last = 1'b1;
        state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (!status.found) begin
          cmd.scan_start = 1'b1;
          state_next = ST_OUT_RD;
        end else if (status.no_edges) begin
          cmd.settle = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end else begin
          cmd.settle = 1'b1;
          state_next = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: begin
        state_next = ST_EDGE_CHK;
      end
      ST_EDGE_CHK: begin
        cmd.edge_chk = 1'b1;
        state_next = ST_EDGE_WB;
      end
      ST_EDGE_WB: begin
        cmd.edge_wb = 1'b1;
        if (status.edge_end) begin
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EDGE_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        cmd.out_load = 1'b1;
        state_next = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = status.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== src/single_source_shortest_paths.sv =====
// top level of the single-source shortest path block
// usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes vertex_count, 0 acting as 1 and
//   values above 64 as 64; cfg_ready is always high, write it only while idle.
//   input channel (in_valid/in_ready): mode 0 stores one edge, one transfer a cycle
//   while idle; edges beyond 256 or naming vertices not below the count are dropped.
//   mode 1 starts a run from source_vertex; in_ready stays low until the last
//   result is taken.
//   a run marks the source, then per settled vertex does a minimum scan (one distance
//   ram read a cycle) and a walk over all stored edges (edge read, distance read,
//   relax and write back per edge); a final scan finds nothing left. a source out
//   of range skips straight to the results. each result is read, loaded into the
//   result register and sent, the send waiting through any receiver stall.
//   out channel (out_valid/out_ready) gives vertex, distance, unreachable, last in
//   vertex order; while the receiver stalls the result register holds.
//   reset sets vertex_count to 64, empties the edge store and returns to idle.
module single_source_shortest_paths import sssp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountBits-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [VertexBits-1:0] from_vertex,
  input  logic [VertexBits-1:0] to_vertex,
  input  logic [15:0]           edge_weight,
  input  logic [VertexBits-1:0] source_vertex,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VertexBits-1:0] vertex,
  output logic [DistBits-1:0]   distance,
  output logic                  unreachable,
  output logic                  last
);
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sssp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  sssp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .from_vertex(from_vertex), .to_vertex(to_vertex), .edge_weight(edge_weight),
    .source_vertex(source_vertex), .vertex(vertex), .distance(distance),
    .unreachable(unreachable), .last(last)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({vertex, distance, unreachable, last}));

  a_busy_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready);
endmodule

// ===== tb/sv/sssp_scoreboard.sv =====
// checker for the shortest path block: tracks graph state, predicts and compares results
`timescale 1ns / 1ps
module sssp_scoreboard import sssp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CountBits-1:0]  cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  mode,
  input  logic [VertexBits-1:0] from_vertex,
  input  logic [VertexBits-1:0] to_vertex,
  input  logic [15:0]           edge_weight,
  input  logic [VertexBits-1:0] source_vertex,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [VertexBits-1:0] vertex,
  input  logic [DistBits-1:0]   distance,
  input  logic                  unreachable,
  input  logic                  last,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [VertexBits-1:0] vertex;
    logic [DistBits-1:0]   distance;
    logic                  unreachable;
    logic                  last;
  } dist_result_t;

  dist_result_t expected_dists[$];

  logic [CountBits-1:0]     vertex_count_q;
  logic [VertexBits-1:0]    tail_q [MaxEdges];
  logic [VertexBits-1:0]    head_q [MaxEdges];
  logic [WeightBits-1:0]    cost_q [MaxEdges];
  int                       edges_held;

  assign pending = expected_dists.size();

  function automatic int vertices_in_use();
    if (vertex_count_q == 0) return 1;
    if (vertex_count_q > MaxVertices) return MaxVertices;
    return int'(vertex_count_q);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // minimum scan over reached, unsettled vertices; edges relaxed in store order
  task automatic predict_distances(int src);
    int n;
    int u;
    longint cand;
    longint path_len [MaxVertices];
    bit reached [MaxVertices];
    bit settled [MaxVertices];
    dist_result_t r;
    n = vertices_in_use();
    for (int v = 0; v < MaxVertices; v++) begin
      path_len[v] = 0;
      reached[v] = 0;
      settled[v] = 0;
    end
    if (src < n) begin
      reached[src] = 1;
      while (1) begin
        u = n;
        for (int v = 0; v < n; v++)
          if (reached[v] && !settled[v] && (u == n || path_len[v] < path_len[u])) u = v;
        if (u == n) break;
        settled[u] = 1;
        for (int e = 0; e < edges_held; e++) begin
          if (tail_q[e] != u || head_q[e] >= n) continue;
          cand = path_len[u] + cost_q[e];
          if (cand > DistMax) cand = DistMax;
          if (!reached[head_q[e]] || cand < path_len[head_q[e]]) begin
            reached[head_q[e]] = 1;
            path_len[head_q[e]] = cand;
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vertex = VertexBits'(v);
      r.unreachable = !reached[v];
      r.distance = reached[v] ? DistBits'(path_len[v]) : DistMax;
      r.last = (v == n - 1);
      expected_dists = {expected_dists, r};
    end
  endtask

  always @(posedge clk) begin
    dist_result_t want;
    if (rst) begin
      errors = 0;
      vertex_count_q <= CountBits'(MaxVertices);
      edges_held <= 0;
      expected_dists.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dists.size() == 0) begin
          report_mismatch("unexpected result transfer, vertex", vertex, -1);
        end else begin
          want = expected_dists.pop_front();
          if (vertex !== want.vertex) report_mismatch("vertex", vertex, want.vertex);
          if (distance !== want.distance)
            report_mismatch("distance", distance, want.distance);
          if (unreachable !== want.unreachable)
            report_mismatch("unreachable", unreachable, want.unreachable);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (cfg_valid && cfg_ready) vertex_count_q <= cfg_data;
      if (in_valid && in_ready) begin
        if (mode == ModeAdd) begin
          if (edges_held < MaxEdges && from_vertex < vertices_in_use() &&
              to_vertex < vertices_in_use()) begin
            tail_q[edges_held] <= from_vertex;
            head_q[edges_held] <= to_vertex;
            cost_q[edges_held] <= edge_weight[WeightBits-1:0];
            edges_held <= edges_held + 1;
          end
        end else begin
          predict_distances(int'(source_vertex));
        end
      end
    end
  end

endmodule

// ===== tb/sv/single_source_shortest_paths_test.sv =====
// testbench top: clock, reset, stimulus and verdict for the shortest path block
`timescale 1ns / 1ps
module single_source_shortest_paths_test;
  import sssp_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CountBits-1:0]  cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  mode;
  logic [VertexBits-1:0] from_vertex;
  logic [VertexBits-1:0] to_vertex;
  logic [15:0]           edge_weight;
  logic [VertexBits-1:0] source_vertex;
  logic                  out_valid;
  logic                  out_ready;
  logic [VertexBits-1:0] vertex;
  logic [DistBits-1:0]   distance;
  logic                  unreachable;
  logic                  last;
  int                    errors;
  int                    pending;
  int                    cur_count;

  single_source_shortest_paths i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready, .mode,
    .from_vertex, .to_vertex, .edge_weight, .source_vertex, .out_valid, .out_ready,
    .vertex, .distance, .unreachable, .last
  );

  sssp_scoreboard i_scoreboard (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready, .mode,
    .from_vertex, .to_vertex, .edge_weight, .source_vertex, .out_valid, .out_ready,
    .vertex, .distance, .unreachable, .last, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver stall pattern: stretches of always ready alternate with random stalls
  int stall_left;
  int ready_window;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      ready_window <= 0;
    end else if (ready_window > 0) begin
      ready_window <= ready_window - 1;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(19) == 0) begin
      ready_window <= $urandom_range(150, 20);
      out_ready <= 1'b1;
    end else begin
      stall_left <= idle_len();
      out_ready <= 1'b1;
    end
  end

  task automatic put_item(logic m, int f, int t, int w, int s);
    int gap;
    mode <= m;
    from_vertex <= VertexBits'(f);
    to_vertex <= VertexBits'(t);
    edge_weight <= 16'(w);
    source_vertex <= VertexBits'(s);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_vertex_count(int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // extra margin; an edge add is already complete once it is accepted
    repeat (6) @(posedge clk);
    cfg_data <= CountBits'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_count = (value == 0) ? 1 : (value > MaxVertices ? MaxVertices : value);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(5))
      0: return 0;
      1: return 16'hFFFF;
      2: return $urandom_range(15);
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  task automatic random_add();
    int f;
    int t;
    // mostly in-range vertices, some beyond the count, a few anywhere
    if ($urandom_range(9) == 0) begin
      f = $urandom_range(63);
      t = $urandom_range(63);
    end else begin
      f = $urandom_range(cur_count + 1 < 63 ? cur_count + 1 : 63);
      t = $urandom_range(cur_count - 1);
    end
    put_item(ModeAdd, f, t, rand_weight(), $urandom_range(63));
  endtask

  task automatic random_run();
    int s;
    s = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(cur_count - 1);
    put_item(ModeRun, $urandom_range(63), $urandom_range(63), $urandom_range(16'hFFFF), s);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = ModeAdd;
    from_vertex = '0;
    to_vertex = '0;
    edge_weight = '0;
    source_vertex = '0;
    cur_count = MaxVertices;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small graph with extremes, dropped edges, loops and odd sources
    write_vertex_count(5);
    put_item(ModeAdd, 0, 1, 0, 0);
    put_item(ModeAdd, 0, 2, 16'hFFFF, 0);
    put_item(ModeAdd, 1, 2, 3, 0);
    put_item(ModeAdd, 2, 3, 1, 0);
    put_item(ModeAdd, 3, 0, 10, 0);
    put_item(ModeAdd, 1, 1, 5, 0);
    put_item(ModeAdd, 7, 1, 2, 0);
    put_item(ModeAdd, 1, 63, 2, 0);
    put_item(ModeAdd, 0, 2, 1, 0);
    put_item(ModeRun, 0, 0, 0, 0);
    put_item(ModeRun, 0, 0, 0, 4);
    put_item(ModeRun, 0, 0, 0, 2);
    put_item(ModeRun, 0, 0, 0, 9);
    write_vertex_count(0);
    put_item(ModeRun, 0, 0, 0, 0);
    put_item(ModeRun, 0, 0, 0, 1);
    write_vertex_count(127);
    put_item(ModeRun, 0, 0, 0, 0);
    put_item(ModeRun, 0, 0, 0, 63);
    write_vertex_count(1);
    put_item(ModeAdd, 0, 0, 4, 0);
    put_item(ModeRun, 0, 0, 0, 0);

    // random phases, mostly small vertex counts; lowering the count skips old edges
    for (int ph = 0; ph < 5; ph++) begin
      write_vertex_count($urandom_range(99) < 80 ? $urandom_range(12, 2) :
                         $urandom_range(24, 13));
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(99) < 20) random_run();
        else random_add();
      end
      random_run();
    end

    // load more edges at full size, then a few full-size runs
    write_vertex_count(64);
    for (int k = 0; k < 50; k++)
      put_item(ModeAdd, $urandom_range(63), $urandom_range(63), rand_weight(), 0);
    put_item(ModeRun, 0, 0, 0, 63);
    put_item(ModeRun, 0, 0, 0, $urandom_range(62));
    write_vertex_count(6);
    put_item(ModeAdd, 1, 2, 3, 0);
    put_item(ModeRun, 0, 0, 0, $urandom_range(5));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
